// ===== rtl/lwpa_pkg.sv =====
// Package for the LCD window pixel access block.
// Frame geometry, operation and scan mode codes, register indexes, shared types.
// No dependencies.
package lwpa_pkg;

  localparam int DISPLAY_WIDTH  = 128;
  localparam int FRAME_ROWS     = 160;
  localparam int STORE_SIZE     = DISPLAY_WIDTH * FRAME_ROWS;
  localparam int ADDR_W         = $clog2(STORE_SIZE);
  localparam int PIX_W          = 16;
  localparam int CNT_W          = 9;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 8;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [2:0] MODE_ROWS_DOWN   = 3'd0;
  localparam logic [2:0] MODE_COLS_UP     = 3'd1;
  localparam logic [2:0] MODE_ROWS_UP     = 3'd2;
  localparam logic [2:0] MODE_ROWS_UP_ALT = 3'd3;
  localparam logic [2:0] MODE_COLS_DOWN   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd4;

  typedef struct packed {
    logic [6:0] left;
    logic [7:0] top;
    logic [7:0] width;
    logic [7:0] height;
    logic [2:0] mode;
  } win_cfg_t;

  typedef struct packed {
    logic              wr;
    logic              rd;
    logic              oor;
    logic [ADDR_W-1:0] addr;
  } acc_t;

endpackage

// ===== rtl/lcd_window_pixel_access_top.sv =====
// Top level of the LCD window pixel access block: config registers,
// access stage, frame store and output register.
// Depends on lwpa_pkg, lwpa_addr, lwpa_ram.
//
//  channel | ports                 | content
//  in      | in_tvalid/tready      | tdata: pixel_in[15:0]; tuser: op; tlast: burst_end
//  out     | out_tvalid/tready     | tdata: pixel_out, pixel_address, out_of_range;
//          |                       | tlast: burst_end_out
//  cfg     | cfg_valid/ready       | cfg_index, cfg_data
//
// One item per cycle unless out stalls; results pass the access and output registers.
// The single frame store port takes one access a cycle; counters update at accept.
// Store contents are not cleared by reset; counters, config and valid flags are.
// Output stalls back up through the access stage to in_tready in the same cycle.
module lcd_window_pixel_access_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [15:0]                         in_tdata,  // [15:0] pixel_in
  input  logic [1:0]                          in_tuser,  // [1:0] op
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata, // [15:0] pixel_out,
                                                         // [30:16] pixel_address,
                                                         // [31] out_of_range
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lwpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lwpa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lwpa_pkg::*;

  win_cfg_t          cfg_r;
  acc_t              acc;
  logic              step;
  logic              s1_adv;
  logic              s1_valid_r;
  logic              s1_rd_r;
  logic              s1_oor_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_last_r;
  logic [PIX_W-1:0]  rdata;
  logic              out_tvalid_r;
  logic [31:0]       out_tdata_r;
  logic              out_tlast_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left   <= 7'd0;
      cfg_r.top    <= 8'd0;
      cfg_r.width  <= 8'd128;
      cfg_r.height <= 8'd160;
      cfg_r.mode   <= MODE_ROWS_UP;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEFT:   cfg_r.left   <= cfg_data[6:0];
        REG_TOP:    cfg_r.top    <= cfg_data;
        REG_WIDTH:  cfg_r.width  <= cfg_data;
        REG_HEIGHT: cfg_r.height <= cfg_data;
        REG_MODE:   cfg_r.mode   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign s1_adv    = s1_valid_r && (!out_tvalid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign step      = in_tvalid && in_tready;

  lwpa_addr u_addr (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .op    (in_tuser),
    .cfg   (cfg_r),
    .acc   (acc)
  );

  lwpa_ram u_ram (
    .clk   (clk),
    .we    (step && acc.wr),
    .re    (step && acc.rd),
    .addr  (acc.addr),
    .wdata (in_tdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (step) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_rd_r   <= acc.rd;
      s1_oor_r  <= acc.oor;
      s1_addr_r <= acc.addr;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (s1_adv) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_tdata_r <= {s1_oor_r, s1_addr_r, s1_rd_r ? rdata : {PIX_W{1'b0}}};
      out_tlast_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  a_oor_no_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[31] |-> out_tdata[30:0] == '0)
    else $error("out-of-range result carries address or pixel");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_addr_r) && $stable(s1_rd_r))
    else $error("access stage lost a stalled item");

  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(acc.wr && acc.rd))
    else $error("read and write on the store port together");

  a_read_flag: assert property (@(posedge clk) disable iff (!rst_n)
    step && acc.rd |=> s1_rd_r && !s1_oor_r)
    else $error("read flag not carried into access stage");

endmodule

// ===== rtl/lwpa_ram.sv =====
// Frame store: single-port synchronous RAM with registered read.
// Depends on lwpa_pkg.
module lwpa_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic                        re,
  input  logic [lwpa_pkg::ADDR_W-1:0] addr,
  input  logic [lwpa_pkg::PIX_W-1:0]  wdata,
  output logic [lwpa_pkg::PIX_W-1:0]  rdata
);
  import lwpa_pkg::*;

  logic [PIX_W-1:0] mem [STORE_SIZE];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lwpa_addr.sv =====
// Window scan counters and store address generation.
// Depends on lwpa_pkg.
module lwpa_addr (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [1:0]         op,
  input  lwpa_pkg::win_cfg_t cfg,
  output lwpa_pkg::acc_t     acc
);
  import lwpa_pkg::*;

  logic [CNT_W-1:0]  col_cnt_r, col_cnt_nxt;
  logic [CNT_W-1:0]  row_cnt_r, row_cnt_nxt;
  logic              act;
  logic              rows_scan;
  logic [CNT_W-1:0]  line_len;
  logic [CNT_W-1:0]  run_cnt;
  logic              wrap;
  logic [CNT_W-1:0]  cc_w, rc_w;
  logic signed [11:0] row_s;
  logic [10:0]       col_u;
  logic signed [21:0] idx_s;
  logic              oor;

  always_comb begin
    act       = (op inside {OP_WRITE, OP_READ}) && (cfg.mode <= MODE_COLS_DOWN) &&
                !(op == OP_READ && cfg.mode == MODE_COLS_DOWN);
    rows_scan = cfg.mode inside {MODE_ROWS_DOWN, MODE_ROWS_UP, MODE_ROWS_UP_ALT};
    line_len  = (rows_scan || cfg.mode == MODE_COLS_UP) ? {1'b0, cfg.width}
                                                         : {1'b0, cfg.height};
    run_cnt   = rows_scan ? col_cnt_r : row_cnt_r;
    wrap      = run_cnt >= line_len;
    cc_w      = col_cnt_r;
    rc_w      = row_cnt_r;
    if (wrap) begin
      if (rows_scan) begin
        cc_w = '0;
        rc_w = row_cnt_r + 1'b1;
      end else begin
        rc_w = '0;
        cc_w = col_cnt_r + 1'b1;
      end
    end

    case (cfg.mode)
      MODE_ROWS_DOWN, MODE_COLS_DOWN: begin
        row_s = $signed({4'b0, cfg.top}) + $signed({3'b0, rc_w});
      end
      MODE_COLS_UP: begin
        row_s = $signed({4'b0, cfg.top}) + $signed({4'b0, cfg.width}) - 12'sd1
                - $signed({3'b0, rc_w});
      end
      default: begin
        row_s = $signed({4'b0, cfg.top}) + $signed({4'b0, cfg.height}) - 12'sd1
                - $signed({3'b0, rc_w});
      end
    endcase

    col_u = {4'b0, cfg.left} + {2'b0, cc_w};
    idx_s = $signed({{10{row_s[11]}}, row_s}) * $signed(22'(DISPLAY_WIDTH))
            + $signed({11'b0, col_u});
    oor   = (idx_s < 22'sd0) || (idx_s >= $signed(22'(STORE_SIZE)));

    acc.wr   = act && (op == OP_WRITE) && !oor;
    acc.rd   = act && (op == OP_READ) && !oor;
    acc.oor  = act && oor;
    acc.addr = (act && !oor) ? idx_s[ADDR_W-1:0] : '0;

    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (step) begin
      if (op == OP_RESTART) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = '0;
      end else if (act) begin
        col_cnt_nxt = rows_scan ? cc_w + 1'b1 : cc_w;
        row_cnt_nxt = rows_scan ? rc_w : rc_w + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && op == OP_RESTART |=> col_cnt_r == '0 && row_cnt_r == '0)
    else $error("counters not cleared after restart");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(col_cnt_r) && $stable(row_cnt_r))
    else $error("counters moved without a transfer");

endmodule
